[hdl/cle_pkg.sv]
`timescale 1ns / 1ps

package cle_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 5;
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam int OP_W     = 4;
	localparam int ITEM_W   = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 3;
	localparam int CPOS_W   = 5;
	localparam int COUNT_W  = 5;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 4'd0,
		OP_REMOVE  = 4'd1,
		OP_REPLACE = 4'd2,
		OP_CLEAR   = 4'd3,
		OP_FIRST   = 4'd4,
		OP_LAST    = 4'd5,
		OP_NEXT    = 4'd6,
		OP_PRIOR   = 4'd7,
		OP_READ    = 4'd8,
		OP_MOVE_TO = 4'd9,
		OP_FIND    = 4'd10
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_RANGE = 3'd3,
		ST_BOUND = 3'd4
	} status_t;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_HOLD    = 9'b000000010,
		S_SH_RD   = 9'b000000100,
		S_SH_WR   = 9'b000001000,
		S_PUT     = 9'b000010000,
		S_FRD     = 9'b000100000,
		S_FCMP    = 9'b001000000,
		S_OUT_RD  = 9'b010000000,
		S_OUT_CAP = 9'b100000000
	} state_t;

endpackage

[hdl/cle_ram.sv]
`timescale 1ns / 1ps

module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/cursor_list_engine_unit.sv]
`timescale 1ns / 1ps
// channel | dir | payload                                               | request when
// s       | in  | tuser: op[3:0]; tdata: item[31:0], position[35:32]    | s_tvalid & s_tready
// m       | out | tdata: status[2:0], cursor_item[34:3], cursor_pos[39:35],
//         |     |   count[44:40], is_empty[45], is_full[46]              | m_tvalid & m_tready
// cfg     | in  | cfg_data: capacity[4:0]                               | cfg_valid & cfg_ready
//
// One command at a time; the result passes S_OUT_RD and S_OUT_CAP, and the next request
// can be taken in the same cycle as the result is offered. Shifts (insert,
// remove, move_to) add S_SH_RD and S_SH_WR per moved entry; insert, replace and move_to end
// with a write in S_PUT, and move_to first takes its hold read in S_HOLD; find steps
// through S_FRD and S_FCMP per entry examined; the single read port is registered.
// Reset clears count and cursor; list storage is not cleared. Output register
// lets a new request be taken while a result waits on m_tready.

module cursor_list_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cle_pkg::S_DATA_W-1:0]  s_tdata,  // item, position
	input  logic [cle_pkg::OP_W-1:0]      s_tuser,  // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cle_pkg::M_DATA_W-1:0]  m_tdata,  // status, cursor_item, cursor_pos,
	                                                // count, is_empty, is_full
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cle_pkg::CAP_W-1:0]     cfg_data  // capacity
);

	localparam int DW  = cle_pkg::DATA_W;
	localparam int IW  = cle_pkg::IDX_W;
	localparam int CW  = cle_pkg::CNT_W;
	localparam int LW  = cle_pkg::LIM_W;
	localparam int PW  = cle_pkg::POS_W;
	localparam int TW  = cle_pkg::ITEM_W;
	localparam int OW  = cle_pkg::M_DATA_W;
	localparam int PAD = OW - cle_pkg::STATUS_W - TW - cle_pkg::CPOS_W
		- cle_pkg::COUNT_W - 2;

	cle_pkg::state_t               state_q;
	logic [CW-1:0]                 fill_q;
	logic [IW-1:0]                 cur_q;
	logic [cle_pkg::CAP_W-1:0]     cap_q;
	logic [DW-1:0]                 item_q;
	cle_pkg::status_t              status_q;
	logic [IW-1:0]                 j_q;
	logic [CW-1:0]                 steps_q;
	logic                          up_q;
	logic                          put_en_q;
	logic [IW-1:0]                 put_addr_q;
	logic [DW-1:0]                 put_data_q;
	logic                          m_valid_q;
	logic [OW-1:0]                 m_data_q;

	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr;
	logic [DW-1:0]                 ram_wdata;
	logic [IW-1:0]                 ram_raddr;
	logic [DW-1:0]                 ram_rdata;

	logic [cle_pkg::OP_W-1:0]      in_op;
	logic [DW-1:0]                 in_item;
	logic [PW-1:0]                 in_pos;
	logic [IW-1:0]                 pos_i;
	logic                          empty;
	logic                          full;
	logic [LW-1:0]                 cap_lim;
	logic                          cur_last;
	logic [IW-1:0]                 ins_at;
	logic                          pos_bad;
	logic                          pos_up;
	logic                          load_out;

	assign in_op   = s_tuser;
	assign in_item = DW'(s_tdata[TW-1:0]);
	assign in_pos  = s_tdata[TW +: PW];
	assign pos_i   = IW'(in_pos);

	assign empty    = (fill_q == '0);
	assign cap_lim  = (LW'(cap_q) > LW'(cle_pkg::DEPTH)) ? LW'(cle_pkg::DEPTH) : LW'(cap_q);
	assign full     = (LW'(fill_q) >= cap_lim);
	assign cur_last = (CW'(cur_q) == fill_q - CW'(1));
	assign ins_at   = empty ? '0 : cur_q + IW'(1);
	assign pos_bad  = (LW'(in_pos) >= LW'(fill_q));
	assign pos_up   = (pos_i < cur_q);

	assign s_tready  = (state_q == cle_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign load_out  = (state_q == cle_pkg::S_OUT_CAP) && (!m_valid_q || m_tready);

	cle_ram #(
		.WIDTH(DW),
		.DEPTH(cle_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_raddr = cur_q;
		ram_we    = 1'b0;
		ram_waddr = put_addr_q;
		ram_wdata = put_data_q;
		unique case (state_q)
			cle_pkg::S_SH_RD: begin
				ram_raddr = up_q ? j_q : j_q + IW'(1);
			end
			cle_pkg::S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = up_q ? j_q + IW'(1) : j_q;
				ram_wdata = ram_rdata;
			end
			cle_pkg::S_PUT: begin
				ram_we = 1'b1;
			end
			cle_pkg::S_FRD: begin
				ram_raddr = j_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cle_pkg::CAP_W'(16);
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cle_pkg::S_IDLE;
			fill_q     <= '0;
			cur_q      <= '0;
			item_q     <= '0;
			status_q   <= cle_pkg::ST_OK;
			j_q        <= '0;
			steps_q    <= '0;
			up_q       <= 1'b0;
			put_en_q   <= 1'b0;
			put_addr_q <= '0;
			put_data_q <= '0;
		end else begin
			unique case (state_q)
				cle_pkg::S_IDLE: begin
					if (s_tvalid) begin
						item_q   <= in_item;
						status_q <= cle_pkg::ST_OK;
						put_en_q <= 1'b0;
						state_q  <= cle_pkg::S_OUT_RD;
						if (empty && in_op != cle_pkg::OP_INSERT && in_op != cle_pkg::OP_CLEAR
							&& in_op <= cle_pkg::OP_FIND) begin
							status_q <= cle_pkg::ST_EMPTY;
						end else begin
							unique case (in_op)
								cle_pkg::OP_INSERT: begin
									if (full) begin
										status_q <= cle_pkg::ST_FULL;
									end else begin
										steps_q    <= fill_q - CW'(ins_at);
										j_q        <= IW'(fill_q - CW'(1));
										up_q       <= 1'b1;
										put_en_q   <= 1'b1;
										put_addr_q <= ins_at;
										put_data_q <= in_item;
										fill_q     <= fill_q + CW'(1);
										cur_q      <= ins_at;
										state_q    <= (fill_q != CW'(ins_at)) ?
											cle_pkg::S_SH_RD : cle_pkg::S_PUT;
									end
								end
								cle_pkg::OP_REMOVE: begin
									steps_q <= fill_q - CW'(1) - CW'(cur_q);
									j_q     <= cur_q;
									up_q    <= 1'b0;
									fill_q  <= fill_q - CW'(1);
									if (cur_last) begin
										cur_q <= '0;
									end
									state_q <= cur_last ? cle_pkg::S_OUT_RD : cle_pkg::S_SH_RD;
								end
								cle_pkg::OP_REPLACE: begin
									put_addr_q <= cur_q;
									put_data_q <= in_item;
									state_q    <= cle_pkg::S_PUT;
								end
								cle_pkg::OP_CLEAR: begin
									fill_q <= '0;
									cur_q  <= '0;
								end
								cle_pkg::OP_FIRST: begin
									cur_q <= '0;
								end
								cle_pkg::OP_LAST: begin
									cur_q <= IW'(fill_q - CW'(1));
								end
								cle_pkg::OP_NEXT: begin
									if (cur_last) begin
										status_q <= cle_pkg::ST_BOUND;
									end else begin
										cur_q <= cur_q + IW'(1);
									end
								end
								cle_pkg::OP_PRIOR: begin
									if (cur_q == '0) begin
										status_q <= cle_pkg::ST_BOUND;
									end else begin
										cur_q <= cur_q - IW'(1);
									end
								end
								cle_pkg::OP_MOVE_TO: begin
									if (pos_bad) begin
										status_q <= cle_pkg::ST_RANGE;
									end else begin
										// hold read of the old cursor entry is in flight
										up_q       <= pos_up;
										steps_q    <= pos_up ? CW'(cur_q - pos_i) : CW'(pos_i - cur_q);
										j_q        <= pos_up ? cur_q - IW'(1) : cur_q;
										put_en_q   <= 1'b1;
										put_addr_q <= pos_i;
										cur_q      <= pos_i;
										state_q    <= cle_pkg::S_HOLD;
									end
								end
								cle_pkg::OP_FIND: begin
									j_q     <= cur_q;
									state_q <= cle_pkg::S_FRD;
								end
								default: begin
								end
							endcase
						end
					end
				end
				cle_pkg::S_HOLD: begin
					put_data_q <= ram_rdata;
					state_q    <= (steps_q != '0) ? cle_pkg::S_SH_RD : cle_pkg::S_PUT;
				end
				cle_pkg::S_SH_RD: begin
					state_q <= cle_pkg::S_SH_WR;
				end
				cle_pkg::S_SH_WR: begin
					j_q     <= up_q ? j_q - IW'(1) : j_q + IW'(1);
					steps_q <= steps_q - CW'(1);
					if (steps_q == CW'(1)) begin
						state_q <= put_en_q ? cle_pkg::S_PUT : cle_pkg::S_OUT_RD;
					end else begin
						state_q <= cle_pkg::S_SH_RD;
					end
				end
				cle_pkg::S_PUT: begin
					state_q <= cle_pkg::S_OUT_RD;
				end
				cle_pkg::S_FRD: begin
					state_q <= cle_pkg::S_FCMP;
				end
				cle_pkg::S_FCMP: begin
					if (ram_rdata == item_q) begin
						cur_q   <= j_q;
						state_q <= cle_pkg::S_OUT_RD;
					end else if (CW'(j_q) == fill_q - CW'(1)) begin
						cur_q    <= j_q;
						status_q <= cle_pkg::ST_BOUND;
						state_q  <= cle_pkg::S_OUT_RD;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= cle_pkg::S_FRD;
					end
				end
				cle_pkg::S_OUT_RD: begin
					state_q <= cle_pkg::S_OUT_CAP;
				end
				cle_pkg::S_OUT_CAP: begin
					if (load_out) begin
						state_q <= cle_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= cle_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (load_out) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {
					PAD'(0),
					full,
					empty,
					cle_pkg::COUNT_W'(fill_q),
					empty ? {cle_pkg::CPOS_W{1'b1}} : cle_pkg::CPOS_W'(cur_q),
					empty ? {TW{1'b0}} : TW'(ram_rdata),
					status_q
				};
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/cle_checker.sv]
`timescale 1ns / 1ps

module cle_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [cle_pkg::M_DATA_W-1:0] m_tdata
);

	logic [2:0]  status;
	logic [31:0] citem;
	logic [4:0]  cpos;
	logic [4:0]  count;
	logic        is_empty;
	logic        is_full;

	assign status   = m_tdata[2:0];
	assign citem    = m_tdata[34:3];
	assign cpos     = m_tdata[39:35];
	assign count    = m_tdata[44:40];
	assign is_empty = m_tdata[45];
	assign is_full  = m_tdata[46];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_empty_view: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && is_empty |-> count == 5'd0 && cpos == 5'h1f && citem == 32'd0)
		else $error("empty list shows a cursor");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !is_empty |-> count != 5'd0 && !cpos[4] && cpos < count)
		else $error("cursor outside the list");

	a_status_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == cle_pkg::ST_FULL |-> is_full)
		else $error("full status without full flag");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == cle_pkg::ST_EMPTY |-> is_empty)
		else $error("empty status on a list that holds entries");

endmodule

bind cursor_list_engine_unit cle_checker u_cle_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

[tb/cle_list_checker.sv]
`timescale 1ns / 1ps

module cle_list_checker import cle_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // item[31:0], position[35:32]
	input  logic [OP_W-1:0]      s_tuser,   // op
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_DATA_W-1:0]  m_tdata,   // status, cursor_item, cursor_pos, count,
	                                        // is_empty, is_full
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CAP_W-1:0]     cfg_data,  // capacity
	output int                   mismatches,
	output int                   pending
);

	typedef struct {
		logic [OP_W-1:0]  cmd;
		status_t          status;
		logic [31:0]      item;
		logic [4:0]       pos;
		logic [4:0]       count;
		logic             is_empty;
		logic             is_full;
	} reply_t;

	logic [31:0]  list_cells [DEPTH];
	int           held_count;
	int           cursor_at;
	logic [4:0]   cap_reg;
	reply_t       expected_replies [$];

	function automatic reply_t step_list(logic [OP_W-1:0] op, logic [31:0] word,
			logic [3:0] tgt);
		status_t      st;
		int           lim;
		int           j;
		int           dest;
		logic [31:0]  held;
		reply_t       r;
		st = ST_OK;
		dest = int'(tgt);
		lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
		if (op != OP_INSERT && op != OP_CLEAR && op <= OP_FIND && held_count == 0) begin
			st = ST_EMPTY;
		end else begin
			case (op)
				OP_INSERT: begin
					if (held_count >= lim || held_count >= DEPTH) begin
						st = ST_FULL;
					end else begin
						for (j = held_count; j > cursor_at + 1; j--)
							list_cells[j] = list_cells[j-1];
						held_count++;
						cursor_at++;
						list_cells[cursor_at] = word;
					end
				end
				OP_REMOVE: begin
					for (j = cursor_at; j < held_count - 1; j++)
						list_cells[j] = list_cells[j+1];
					held_count--;
					if (held_count == 0)
						cursor_at = -1;
					else if (cursor_at == held_count)
						cursor_at = 0;
				end
				OP_REPLACE: list_cells[cursor_at] = word;
				OP_CLEAR: begin
					held_count = 0;
					cursor_at = -1;
				end
				OP_FIRST: cursor_at = 0;
				OP_LAST: cursor_at = held_count - 1;
				OP_NEXT: begin
					if (cursor_at != held_count - 1)
						cursor_at++;
					else
						st = ST_BOUND;
				end
				OP_PRIOR: begin
					if (cursor_at != 0)
						cursor_at--;
					else
						st = ST_BOUND;
				end
				OP_MOVE_TO: begin
					if (dest >= held_count) begin
						st = ST_RANGE;
					end else begin
						held = list_cells[cursor_at];
						if (dest < cursor_at) begin
							for (j = cursor_at - 1; j >= dest; j--)
								list_cells[j+1] = list_cells[j];
						end else begin
							for (j = cursor_at; j < dest; j++)
								list_cells[j] = list_cells[j+1];
						end
						list_cells[dest] = held;
						cursor_at = dest;
					end
				end
				OP_FIND: begin
					while (cursor_at < held_count && list_cells[cursor_at] != word)
						cursor_at++;
					if (cursor_at >= held_count) begin
						cursor_at = held_count - 1;
						st = ST_BOUND;
					end
				end
				default: ;
			endcase
		end
		r.cmd = op;
		r.status = st;
		if (held_count > 0) begin
			r.item = list_cells[cursor_at];
			r.pos = 5'(cursor_at);
		end else begin
			r.item = '0;
			r.pos = '1;
		end
		r.count = 5'(held_count);
		r.is_empty = (held_count == 0);
		r.is_full = (held_count >= lim);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			held_count = 0;
			cursor_at = -1;
			cap_reg = 5'd16;
			expected_replies.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tdata[2:0]);
				got.item = m_tdata[34:3];
				got.pos = m_tdata[39:35];
				got.count = m_tdata[44:40];
				got.is_empty = m_tdata[45];
				got.is_full = m_tdata[46];
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reply: status %0d item %h pos %0d count %0d",
							got.status, got.item, got.pos, got.count);
				end else begin
					want = expected_replies.pop_front();
					if (got.status != want.status || got.item != want.item ||
							got.pos != want.pos || got.count != want.count ||
							got.is_empty != want.is_empty || got.is_full != want.is_full) begin
						mismatches++;
						if (mismatches <= 10)
							$display("reply mismatch on op %0d: want st %0d item %h pos %0d ",
								want.cmd, want.status, want.item, want.pos,
								"cnt %0d e %b f %b; got st %0d item %h pos %0d cnt %0d e %b f %b",
								want.count, want.is_empty, want.is_full, got.status,
								got.item, got.pos, got.count, got.is_empty, got.is_full);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_replies.push_back(step_list(s_tuser, s_tdata[31:0], s_tdata[35:32]));
		end
		pending = expected_replies.size();
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import cle_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 275;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd11;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;   // item[31:0], position[35:32]
	logic [OP_W-1:0]      s_tuser;   // op
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;   // status, cursor_item, cursor_pos, count,
	                                 // is_empty, is_full
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CAP_W-1:0]     cfg_data;  // capacity
	int                   mismatches;
	int                   pending;
	int                   send_idle_pct;
	int                   recv_idle_pct;
	int                   holds_asked;
	int                   quiet_cycles;

	cursor_list_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	cle_list_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result side: random back-pressure, plus a long hold-off on request
	initial begin
		int holds_served;
		holds_served = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				m_tready <= 1'b0;
				holds_served++;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [31:0] word,
			input logic [3:0] tgt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, tgt, word};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain_replies();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 22) return OP_INSERT;
		if (r < 35) return OP_REMOVE;
		if (r < 40) return OP_REPLACE;
		if (r < 42) return OP_CLEAR;
		if (r < 47) return OP_FIRST;
		if (r < 52) return OP_LAST;
		if (r < 62) return OP_NEXT;
		if (r < 71) return OP_PRIOR;
		if (r < 75) return OP_READ;
		if (r < 86) return OP_MOVE_TO;
		if (r < 98) return OP_FIND;
		return 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
	endfunction

	// a small pool of words keeps finds hitting often
	function automatic logic [31:0] pick_word();
		if ($urandom_range(1))
			return 32'($urandom_range(7)) * 32'h9E3779B9;
		return $urandom;
	endfunction

	task automatic run_random(input int n, input bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == 100)
				holds_asked++;
			send_cmd(pick_op(), pick_word(), 4'($urandom_range(15)));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		holds_asked = 0;
		send_idle_pct = 12;
		recv_idle_pct = 50;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(OP_REMOVE, 32'h0, 4'd0);
		send_cmd(OP_NEXT, 32'h0, 4'd0);
		send_cmd(OP_MOVE_TO, 32'h0, 4'd15);
		send_cmd(OP_FIND, 32'h0, 4'd0);
		send_cmd(OP_SPARE_HI, 32'hFFFFFFFF, 4'd15);
		send_cmd(OP_CLEAR, 32'h0, 4'd0);
		send_cmd(OP_INSERT, 32'h00000000, 4'd0);
		send_cmd(OP_INSERT, 32'hFFFFFFFF, 4'd0);
		send_cmd(OP_INSERT, 32'hA5A55A5A, 4'd0);
		send_cmd(OP_NEXT, 32'h0, 4'd0);
		send_cmd(OP_FIRST, 32'h0, 4'd0);
		send_cmd(OP_PRIOR, 32'h0, 4'd0);
		send_cmd(OP_FIND, 32'hDEADBEEF, 4'd0);
		send_cmd(OP_FIRST, 32'h0, 4'd0);
		send_cmd(OP_FIND, 32'hFFFFFFFF, 4'd0);
		send_cmd(OP_MOVE_TO, 32'h0, 4'd15);
		send_cmd(OP_MOVE_TO, 32'h0, 4'd0);
		send_cmd(OP_REPLACE, 32'h12345678, 4'd0);
		send_cmd(OP_LAST, 32'h0, 4'd0);
		send_cmd(OP_REMOVE, 32'h0, 4'd0);
		send_cmd(OP_READ, 32'h0, 4'd0);
		send_cmd(OP_MOVE_TO, 32'h0, 4'd1);
		write_capacity(5'd1);
		send_cmd(OP_INSERT, 32'h5555AAAA, 4'd0);
		write_capacity(5'd0);
		send_cmd(OP_INSERT, 32'h0000FFFF, 4'd0);
		send_cmd(OP_CLEAR, 32'h0, 4'd0);
		send_cmd(OP_INSERT, 32'hFFFF0000, 4'd0);

		write_capacity(5'd31);
		run_random(PHASE_ITEMS, 1'b0);

		send_idle_pct = 50;
		recv_idle_pct = 12;
		write_capacity(5'd5);
		run_random(PHASE_ITEMS, 1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_capacity(5'd16);
		run_random(PHASE_ITEMS, 1'b1);

		drain_replies();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
